>>> hdl/qrs_pkg.sv
package qrs_pkg;

    // Field widths fixed by the interface
    localparam int COEF_W        = 16;
    localparam int OUT_W         = 40;
    localparam int FRAC_BITS_DEF = 16;

    // Width of |D| = |b*b - 4ac|, always below 2^33
    localparam int DISC_W = 33;

    // Divisor 2a as a signed value
    localparam int DEN_W = COEF_W + 1;

    typedef enum logic [1:0] {
        KIND_TWO_REAL = 2'd0,
        KIND_DOUBLE   = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_A_ZERO   = 2'd3
    } root_kind_t;

endpackage

>>> hdl/qrs_sqrt.sv
// Pipelined integer square root, one result digit per stage.
// out_root = floor(sqrt(in_mag * 4^FRAC_BITS)).
module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int IN_W      = DISC_W,
    parameter int SIDE_W    = 8
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [IN_W-1:0]                      in_mag,
    input  logic [SIDE_W-1:0]                    in_side,
    output logic                                 out_valid,
    output logic [(IN_W+1)/2+FRAC_BITS-1:0]      out_root,
    output logic [SIDE_W-1:0]                    out_side
);

    localparam int DIGITS = (IN_W + 1) / 2 + FRAC_BITS;
    localparam int ROOT_W = DIGITS;
    localparam int REM_W  = ROOT_W + 2;
    localparam int OP_W   = 2 * DIGITS;

    logic              valid_reg [1:DIGITS];
    logic [REM_W-1:0]  rem_reg   [1:DIGITS];
    logic [ROOT_W-1:0] root_reg  [1:DIGITS];
    logic [OP_W-1:0]   op_reg    [1:DIGITS];
    logic [SIDE_W-1:0] side_reg  [1:DIGITS];

    genvar k;
    generate
        for (k = 0; k < DIGITS; k++)
        begin : g_stage
            logic              v_cur;
            logic [REM_W-1:0]  rem_cur;
            logic [ROOT_W-1:0] root_cur;
            logic [OP_W-1:0]   op_cur;
            logic [SIDE_W-1:0] side_cur;
            logic [REM_W-1:0]  rem_cat;
            logic [REM_W-1:0]  trial;

            if (k == 0)
            begin : g_first
                // operand left aligned, fraction digits come in as zero pairs
                assign v_cur    = in_valid;
                assign rem_cur  = '0;
                assign root_cur = '0;
                assign op_cur   = OP_W'(in_mag) << (2 * FRAC_BITS);
                assign side_cur = in_side;
            end
            else
            begin : g_next
                assign v_cur    = valid_reg[k];
                assign rem_cur  = rem_reg[k];
                assign root_cur = root_reg[k];
                assign op_cur   = op_reg[k];
                assign side_cur = side_reg[k];
            end

            // bring down the next digit pair and try the subtraction
            assign rem_cat = {rem_cur[REM_W-3:0], op_cur[OP_W-1 -: 2]};
            assign trial   = {root_cur, 2'b01};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k+1] <= v_cur;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rem_cat >= trial)
                    begin
                        rem_reg[k+1]  <= rem_cat - trial;
                        root_reg[k+1] <= {root_cur[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k+1]  <= rem_cat;
                        root_reg[k+1] <= {root_cur[ROOT_W-2:0], 1'b0};
                    end
                    op_reg[k+1]   <= op_cur << 2;
                    side_reg[k+1] <= side_cur;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[DIGITS];
    assign out_root  = root_reg[DIGITS];
    assign out_side  = side_reg[DIGITS];

endmodule

>>> hdl/qrs_div.sv
// Pipelined signed division of two numerators by one divisor, one quotient
// bit per stage, truncating toward zero. Gives magnitude and sign apart.
module qrs_div
    import qrs_pkg::*;
#(
    parameter int NUM_W  = FRAC_BITS_DEF + 19,
    parameter int SIDE_W = 2
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [NUM_W:0]        in_num0,
    input  logic signed [NUM_W:0]        in_num1,
    input  logic signed [DEN_W-1:0]      in_den,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [1:0][NUM_W-1:0]        out_quo,
    output logic [1:0]                   out_neg,
    output logic [SIDE_W-1:0]            out_side
);

    logic                          valid_reg [1:NUM_W];
    logic [DEN_W-1:0]              dv_reg    [1:NUM_W];
    logic [SIDE_W-1:0]             side_reg  [1:NUM_W];
    logic [1:0]                    neg_reg   [1:NUM_W];
    logic [1:0][DEN_W-1:0]         rem_reg   [1:NUM_W];
    logic [1:0][NUM_W-1:0]         nq_reg    [1:NUM_W];

    // magnitudes and quotient signs at entry
    logic [DEN_W-1:0]              dv0;
    logic [1:0][NUM_W-1:0]         nq0;
    logic [1:0]                    neg0;
    logic [NUM_W:0]                n0_abs;
    logic [NUM_W:0]                n1_abs;

    always_comb
    begin
        dv0     = in_den[DEN_W-1] ? DEN_W'(-in_den) : in_den;
        n0_abs  = in_num0[NUM_W] ? -in_num0 : in_num0;
        n1_abs  = in_num1[NUM_W] ? -in_num1 : in_num1;
        nq0[0]  = n0_abs[NUM_W-1:0];
        nq0[1]  = n1_abs[NUM_W-1:0];
        neg0[0] = in_num0[NUM_W] ^ in_den[DEN_W-1];
        neg0[1] = in_num1[NUM_W] ^ in_den[DEN_W-1];
    end

    genvar k, l;
    generate
        for (k = 0; k < NUM_W; k++)
        begin : g_stage
            logic                  v_cur;
            logic [DEN_W-1:0]      dv_cur;
            logic [SIDE_W-1:0]     side_cur;
            logic [1:0]            neg_cur;
            logic [1:0][DEN_W-1:0] rem_cur;
            logic [1:0][NUM_W-1:0] nq_cur;

            if (k == 0)
            begin : g_first
                assign v_cur    = in_valid;
                assign dv_cur   = dv0;
                assign side_cur = in_side;
                assign neg_cur  = neg0;
                assign rem_cur  = '0;
                assign nq_cur   = nq0;
            end
            else
            begin : g_next
                assign v_cur    = valid_reg[k];
                assign dv_cur   = dv_reg[k];
                assign side_cur = side_reg[k];
                assign neg_cur  = neg_reg[k];
                assign rem_cur  = rem_reg[k];
                assign nq_cur   = nq_reg[k];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k+1] <= v_cur;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_reg[k+1]   <= dv_cur;
                    side_reg[k+1] <= side_cur;
                    neg_reg[k+1]  <= neg_cur;
                end
            end

            // restoring step per lane: shift in a numerator bit, try subtract
            for (l = 0; l < 2; l++)
            begin : g_lane
                logic [DEN_W:0] shifted;
                logic           take;

                assign shifted = {rem_cur[l], nq_cur[l][NUM_W-1]};
                assign take    = (shifted >= {1'b0, dv_cur});

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        if (take)
                        begin
                            rem_reg[k+1][l] <= DEN_W'(shifted - {1'b0, dv_cur});
                        end
                        else
                        begin
                            rem_reg[k+1][l] <= shifted[DEN_W-1:0];
                        end
                        nq_reg[k+1][l] <= {nq_cur[l][NUM_W-2:0], take};
                    end
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NUM_W];
    assign out_quo   = nq_reg[NUM_W];
    assign out_neg   = neg_reg[NUM_W];
    assign out_side  = side_reg[NUM_W];

endmodule

>>> hdl/quadratic_root_solver_core.sv
// Channel | Signals                                   | Direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_stall, coef_a/b/c            | item in
// out     | out_valid, out_stall, root_kind,          | item out
//         | first_value, second_value                 |
//
// One item per cycle while the output is not stalled; the depth comes mostly from the
// square root (one digit per stage) and the divider (one bit per stage).
// Reset clears the valid bits of every stage; no clearing pass.
// A stall on the output freezes the whole pipeline and raises in_stall only
// while a result is held at the output.
module quadratic_root_solver_core
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [COEF_W-1:0] coef_a,
    input  logic signed [COEF_W-1:0] coef_b,
    input  logic signed [COEF_W-1:0] coef_c,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               root_kind,
    output logic signed [OUT_W-1:0]  first_value,
    output logic signed [OUT_W-1:0]  second_value
);

    localparam int NB_W   = FRAC_BITS + 17;
    localparam int ROOT_W = (DISC_W + 1) / 2 + FRAC_BITS;
    localparam int NUM_W  = FRAC_BITS + 19;
    localparam int SIDE_W = 2 + DEN_W + NB_W;
    localparam int WIDE_W = (NUM_W + 1 > OUT_W) ? NUM_W + 1 : OUT_W;

    logic en;

    // global advance: hold everything while the output item waits
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // stage 1: products
    logic                     s1_valid_reg;
    logic signed [COEF_W-1:0] s1_a_reg;
    logic signed [COEF_W-1:0] s1_b_reg;
    logic signed [31:0]       s1_bb_reg;
    logic signed [31:0]       s1_ac_reg;
    logic signed [31:0]       s1_bb_next;
    logic signed [31:0]       s1_ac_next;

    assign s1_bb_next = coef_b * coef_b;
    assign s1_ac_next = coef_a * coef_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_a_reg  <= coef_a;
            s1_b_reg  <= coef_b;
            s1_bb_reg <= s1_bb_next;
            s1_ac_reg <= s1_ac_next;
        end
    end

    // stage 2: discriminant, kind, divisor and scaled -b
    logic                   s2_valid_reg;
    root_kind_t             s2_kind_reg;
    root_kind_t             s2_kind_next;
    logic [DISC_W-1:0]      s2_mag_reg;
    logic [DISC_W-1:0]      s2_mag_next;
    logic [DEN_W-1:0]       s2_den_reg;
    logic [NB_W-1:0]        s2_nb_reg;
    logic [NB_W-1:0]        s2_nb_next;
    logic signed [DISC_W:0] disc;
    logic [COEF_W:0]        negb;

    always_comb
    begin
        disc        = {{2{s1_bb_reg[31]}}, s1_bb_reg} - {s1_ac_reg, 2'b00};
        s2_mag_next = disc[DISC_W] ? DISC_W'(-disc) : disc[DISC_W-1:0];
        negb        = -{s1_b_reg[COEF_W-1], s1_b_reg};
        s2_nb_next  = {negb, {FRAC_BITS{1'b0}}};
        if (s1_a_reg == '0)
        begin
            s2_kind_next = KIND_A_ZERO;
        end
        else if (disc[DISC_W])
        begin
            s2_kind_next = KIND_COMPLEX;
        end
        else if (disc == '0)
        begin
            s2_kind_next = KIND_DOUBLE;
        end
        else
        begin
            s2_kind_next = KIND_TWO_REAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_kind_reg <= s2_kind_next;
            s2_mag_reg  <= s2_mag_next;
            s2_den_reg  <= {s1_a_reg, 1'b0};
            s2_nb_reg   <= s2_nb_next;
        end
    end

    // square root of |D|
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [SIDE_W-1:0] sq_side;

    qrs_sqrt #(
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (DISC_W),
        .SIDE_W    (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_mag    (s2_mag_reg),
        .in_side   ({s2_kind_reg, s2_den_reg, s2_nb_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // stage 3: numerators per kind
    root_kind_t             sq_kind;
    logic [NB_W-1:0]        sq_nb;
    logic signed [NUM_W:0]  nb_ext;
    logic signed [NUM_W:0]  root_ext;
    logic                   s3_valid_reg;
    root_kind_t             s3_kind_reg;
    logic signed [DEN_W-1:0] s3_den_reg;
    logic signed [NUM_W:0]  s3_n0_reg;
    logic signed [NUM_W:0]  s3_n1_reg;
    logic signed [NUM_W:0]  s3_n0_next;
    logic signed [NUM_W:0]  s3_n1_next;

    always_comb
    begin
        sq_kind  = root_kind_t'(sq_side[SIDE_W-1 -: 2]);
        sq_nb    = sq_side[NB_W-1:0];
        nb_ext   = {{(NUM_W+1-NB_W){sq_nb[NB_W-1]}}, sq_nb};
        root_ext = {{(NUM_W+1-ROOT_W){1'b0}}, sq_root};
        case (sq_kind)
            KIND_TWO_REAL:
            begin
                s3_n0_next = nb_ext + root_ext;
                s3_n1_next = nb_ext - root_ext;
            end
            KIND_COMPLEX:
            begin
                s3_n0_next = nb_ext;
                s3_n1_next = root_ext;
            end
            default:
            begin
                s3_n0_next = nb_ext;
                s3_n1_next = nb_ext;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_kind_reg <= sq_kind;
            s3_den_reg  <= sq_side[NB_W +: DEN_W];
            s3_n0_reg   <= s3_n0_next;
            s3_n1_reg   <= s3_n1_next;
        end
    end

    // division by 2a
    logic                  dv_valid;
    logic [1:0][NUM_W-1:0] dv_quo;
    logic [1:0]            dv_neg;
    logic [1:0]            dv_side;

    qrs_div #(
        .NUM_W     (NUM_W),
        .SIDE_W    (2)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_num0   (s3_n0_reg),
        .in_num1   (s3_n1_reg),
        .in_den    (s3_den_reg),
        .in_side   (s3_kind_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_neg   (dv_neg),
        .out_side  (dv_side)
    );

    // output stage: sign, saturate, zero for a == 0
    localparam logic signed [WIDE_W-1:0] SAT_HI =
        WIDE_W'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - WIDE_W'(1);

    logic                     out_valid_reg;
    logic [1:0]               out_kind_reg;
    logic signed [OUT_W-1:0]  out_first_reg;
    logic signed [OUT_W-1:0]  out_second_reg;
    logic [1:0][OUT_W-1:0]    val_next;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic signed [NUM_W:0]    sval;
            logic signed [WIDE_W-1:0] wval;
            sval = dv_neg[l] ? -{1'b0, dv_quo[l]} : {1'b0, dv_quo[l]};
            wval = {{(WIDE_W-NUM_W-1+1){sval[NUM_W]}}, sval[NUM_W-1:0]};
            if (dv_side == KIND_A_ZERO)
            begin
                val_next[l] = '0;
            end
            else if (wval > SAT_HI)
            begin
                val_next[l] = SAT_HI[OUT_W-1:0];
            end
            else if (wval < SAT_LO)
            begin
                val_next[l] = SAT_LO[OUT_W-1:0];
            end
            else
            begin
                val_next[l] = wval[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_kind_reg   <= dv_side;
            out_first_reg  <= val_next[0];
            out_second_reg <= val_next[1];
        end
    end

    assign out_valid    = out_valid_reg;
    assign root_kind    = out_kind_reg;
    assign first_value  = out_first_reg;
    assign second_value = out_second_reg;

    // a zero gives zero results
    a_zero_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && root_kind == KIND_A_ZERO) |-> (first_value == '0 && second_value == '0))
        else $error("a zero item with non-zero results");

    // double root repeats itself
    double_root_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && root_kind == KIND_DOUBLE) |-> (first_value == second_value))
        else $error("double root values differ");

    // input is held back only for a waiting output item
    stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with no held output item");

    // a held output item does not move
    held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(first_value)
            && $stable(second_value)))
        else $error("held output item changed");

endmodule

>>> tb/tb_quadratic_root_solver_core.sv
`timescale 1ns / 100ps

module tb_quadratic_root_solver_core;
    import qrs_pkg::*;

    localparam int FB      = FRAC_BITS_DEF;
    localparam int LATENCY = 2 * FB + 40;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               root_kind;
    logic signed [OUT_W-1:0]  first_value;
    logic signed [OUT_W-1:0]  second_value;

    typedef struct packed {
        root_kind_t              kind;
        logic signed [OUT_W-1:0] first;
        logic signed [OUT_W-1:0] second;
    } roots_t;

    typedef struct {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        bit                       fixed;
        roots_t                   want;
    } coef_row_t;

    roots_t    pending_roots[$];
    coef_row_t rows[$];
    int        n_fail;
    int        n_sent;
    int        n_seen;
    bit        feeding_done;

    quadratic_root_solver_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .coef_a       (coef_a),
        .coef_b       (coef_b),
        .coef_c       (coef_c),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .root_kind    (root_kind),
        .first_value  (first_value),
        .second_value (second_value)
    );

    always #5 clk = ~clk;

    // Floor of sqrt(d * 4^FB), bit by bit
    function automatic logic [63:0] fixed_isqrt(input logic [63:0] d);
        logic [127:0] v;
        logic [127:0] r;
        logic [127:0] t;
        v = {64'd0, d} << (2 * FB);
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            t = r | (128'd1 << i);
            if (t * t <= v)
                r = t;
        end
        return r[63:0];
    endfunction

    // Truncating divide, saturated to the output width
    function automatic logic signed [OUT_W-1:0] div_sat(input longint num, input longint den);
        longint q;
        longint hi;
        hi = (longint'(1) <<< (OUT_W - 1)) - 1;
        q  = num / den;
        if (q > hi)
            q = hi;
        if (q < -hi - 1)
            q = -hi - 1;
        return q[OUT_W-1:0];
    endfunction

    function automatic roots_t solve_roots(input logic signed [COEF_W-1:0] a,
                                           input logic signed [COEF_W-1:0] b,
                                           input logic signed [COEF_W-1:0] c);
        roots_t r;
        longint la;
        longint lb;
        longint lc;
        longint disc;
        longint nb;
        longint s;
        la = a;
        lb = b;
        lc = c;
        if (la == 0)
        begin
            r.kind   = KIND_A_ZERO;
            r.first  = '0;
            r.second = '0;
            return r;
        end
        disc = lb * lb - 4 * la * lc;
        nb   = -lb * (longint'(1) <<< FB);
        if (disc > 0)
        begin
            s        = longint'(fixed_isqrt(disc));
            r.kind   = KIND_TWO_REAL;
            r.first  = div_sat(nb + s, 2 * la);
            r.second = div_sat(nb - s, 2 * la);
        end
        else if (disc == 0)
        begin
            r.kind   = KIND_DOUBLE;
            r.first  = div_sat(nb, 2 * la);
            r.second = r.first;
        end
        else
        begin
            s        = longint'(fixed_isqrt(-disc));
            r.kind   = KIND_COMPLEX;
            r.first  = div_sat(nb, 2 * la);
            r.second = div_sat(s, 2 * la);
        end
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 15)) - 16'd8;
            1:       return 16'($urandom_range(0, 255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_row(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
                           input bit fixed, input roots_t want);
        coef_row_t row;
        row.a     = a;
        row.b     = b;
        row.c     = c;
        row.fixed = fixed;
        row.want  = want;
        rows.push_back(row);
    endtask

    // Hold one item on the input until it is taken; valid stays high for a
    // following item with no gap
    task automatic send_coefs(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        coef_a   <= a;
        coef_b   <= b;
        coef_c   <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Accepted inputs are predicted at the edge they are taken
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            pending_roots.push_back(solve_roots(coef_a, coef_b, coef_c));
            n_sent++;
        end
    end

    // Result check
    always @(posedge clk)
    begin
        roots_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            n_seen++;
            if (pending_roots.size() == 0)
            begin
                $display("%0t: unexpected item kind=%0d first=%0d second=%0d",
                         $time, root_kind, first_value, second_value);
                n_fail++;
            end
            else
            begin
                e = pending_roots.pop_front();
                if (root_kind !== e.kind)
                begin
                    $display("%0t: root_kind expected %0d actual %0d", $time, e.kind, root_kind);
                    n_fail++;
                end
                if (first_value !== e.first)
                begin
                    $display("%0t: first_value expected %0d actual %0d",
                             $time, e.first, first_value);
                    n_fail++;
                end
                if (second_value !== e.second)
                begin
                    $display("%0t: second_value expected %0d actual %0d",
                             $time, e.second, second_value);
                    n_fail++;
                end
            end
        end
    end

    // Receiver back-pressure
    initial
    begin
        int g;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (feeding_done || $urandom_range(0, 3) != 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 30)) @(negedge clk);
            end
            else
            begin
                g = gap_len();
                if (g > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (g) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb_quadratic_root_solver_core: FAIL");
        $finish;
    end

    initial
    begin
        roots_t    nil;
        roots_t    az;
        coef_row_t row;
        int        waited;
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        coef_a       = '0;
        coef_b       = '0;
        coef_c       = '0;
        n_fail       = 0;
        n_sent       = 0;
        n_seen       = 0;
        feeding_done = 0;
        nil          = '0;
        az           = '{KIND_A_ZERO, '0, '0};
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: a zero, extremes, each root kind, sign of a
        add_row(16'd0, 16'd0, 16'd0, 1, az);
        add_row(16'd0, 16'h7fff, 16'h8000, 1, az);
        add_row(16'd0, 16'h8000, 16'h7fff, 1, az);
        add_row(16'd1, 16'd0, 16'd0, 1, '{KIND_DOUBLE, '0, '0});
        add_row(16'd1, 16'd0, 16'hfffc, 1, '{KIND_TWO_REAL, 40'sd131072, -40'sd131072});
        add_row(16'd1, 16'd0, 16'd4, 1, '{KIND_COMPLEX, '0, 40'sd131072});
        add_row(16'd1, 16'hfffe, 16'd1, 1, '{KIND_DOUBLE, 40'sd65536, 40'sd65536});
        add_row(16'hffff, 16'd0, 16'd4, 0, nil);
        add_row(16'hffff, 16'd0, 16'hfffc, 0, nil);
        add_row(16'h7fff, 16'h7fff, 16'h7fff, 0, nil);
        add_row(16'h8000, 16'h8000, 16'h8000, 0, nil);
        add_row(16'h8000, 16'h7fff, 16'h7fff, 0, nil);
        add_row(16'h7fff, 16'h8000, 16'h8000, 0, nil);
        add_row(16'd1, 16'h8000, 16'h8000, 0, nil);
        add_row(16'hffff, 16'h7fff, 16'h7fff, 0, nil);
        add_row(16'd1, 16'h8000, 16'h7fff, 0, nil);
        add_row(16'hffff, 16'h8000, 16'h8000, 0, nil);
        add_row(16'h0003, 16'h0007, 16'hfffb, 0, nil);
        add_row(16'hfffd, 16'h0005, 16'h0002, 0, nil);
        add_row(16'h0004, 16'h0004, 16'h0001, 0, nil);
        add_row(16'h8000, 16'd0, 16'd0, 0, nil);
        add_row(16'h7fff, 16'd0, 16'h7fff, 0, nil);
        foreach (rows[i])
        begin
            row = rows[i];
            if (row.fixed && solve_roots(row.a, row.b, row.c) !== row.want)
            begin
                $display("%0t: table row %0d expected %p predictor %p",
                         $time, i, row.want, solve_roots(row.a, row.b, row.c));
                n_fail++;
            end
            send_coefs(row.a, row.b, row.c);
        end

        // Random part, with one full drain in the middle
        for (int k = 0; k < 850; k++)
        begin
            if (k == 400)
            begin
                in_valid <= 1'b0;
                while (pending_roots.size() != 0)
                    @(negedge clk);
            end
            case ($urandom_range(0, 9))
                0:       send_coefs(16'd0, 16'($urandom), 16'($urandom));
                1:       send_coefs(rand_coef(), 16'd2 * 16'($urandom_range(0, 200)),
                                    16'($urandom_range(0, 40)));
                default: send_coefs(rand_coef(), rand_coef(), rand_coef());
            endcase
        end
        in_valid     <= 1'b0;
        feeding_done = 1;

        waited = 0;
        while (pending_roots.size() != 0 && waited < 100 * LATENCY)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(negedge clk);
        if (pending_roots.size() != 0)
        begin
            $display("%0t: %0d expected items never arrived", $time, pending_roots.size());
            n_fail++;
        end

        $display("Sent %0d coefficient sets (%0d directed), checked %0d root items.",
                 n_sent, rows.size(), n_seen);
        $display("Covered a zero, all root kinds, coefficient extremes and random stalls.");
        if (n_fail == 0)
            $display("tb_quadratic_root_solver_core: PASS");
        else
            $display("tb_quadratic_root_solver_core: FAIL");
        $finish;
    end

endmodule

>>> quadratic_root_solver_core.f
hdl/qrs_pkg.sv
hdl/qrs_sqrt.sv
hdl/qrs_div.sv
hdl/quadratic_root_solver_core.sv
tb/tb_quadratic_root_solver_core.sv
